// File: rtl/assert_macros.svh
// Assertion helpers, sampled on clk, disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define FFSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ffsa_pkg.sv
package ffsa_pkg;

    localparam int SIZE_BITS   = 16;
    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 3;

    localparam logic [KIND_BITS-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_FREE    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_CREATE  = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_DESTROY = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_POOL   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_EXCEEDED  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NO_SPACE  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_EXISTS    = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 3'd5;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CREATE,
        OP_DESTROY,
        OP_FINISH,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_NEXT,
        OP_HIT,
        OP_EXACT,
        OP_SHUP_INIT,
        OP_SHUP_RD,
        OP_SHUP_WR,
        OP_SPLIT_LO,
        OP_SPLIT_HI,
        OP_FREE_HIT,
        OP_NX_RD,
        OP_NX_MERGE,
        OP_PV_RD,
        OP_PV_MERGE,
        OP_MERGE_WR,
        OP_SHDN_RD,
        OP_SHDN_WR,
        OP_SHDN_DONE
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_ALLOC_DEC,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SPLIT_LO,
        S_SPLIT_HI,
        S_NX_RD,
        S_NX_CHK,
        S_PV_RD,
        S_PV_CHK,
        S_MERGE_WR,
        S_SHDN_RD,
        S_SHDN_WR,
        S_FIN
    } state_t;

    typedef struct packed {
        op_t                    op;
        logic [STATUS_BITS-1:0] status;
        logic                   in_ready;
    } ctl_cmd_t;

    typedef struct packed {
        logic                 in_valid;
        logic                 out_free;
        logic [KIND_BITS-1:0] kind;
        logic                 pool;
        logic                 exceeded;
        logic                 req_zero;
        logic                 is_null;
        logic                 idx_end;
        logic                 hit;
        logic                 exact;
        logic                 full;
        logic                 ptr_gt_idx;
        logic                 has_next;
        logic                 has_prev;
        logic                 rd_free;
        logic                 shdn_end;
    } dp_flags_t;

endpackage

// File: rtl/ffsa_if.sv
interface ffsa_req_if;
    import ffsa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] kind;
    logic [SIZE_BITS-1:0] request_size;
    logic [SIZE_BITS-1:0] block_addr;
    logic                 block_null;

    modport source (output valid, kind, request_size, block_addr, block_null, input ready);
    modport sink (input valid, kind, request_size, block_addr, block_null, output ready);
endinterface

interface ffsa_rsp_if;
    import ffsa_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [SIZE_BITS-1:0]   offset;

    modport source (output valid, status, offset, input ready);
    modport sink (input valid, status, offset, output ready);
endinterface

// File: rtl/ffsa_ram.sv
module ffsa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/ffsa_ctrl.sv
module ffsa_ctrl import ffsa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  dp_flags_t flags,
    output ctl_cmd_t  cmd
);

    state_t                 state_reg, state_next;
    logic [STATUS_BITS-1:0] st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (flags.in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FIN;
                st_next    = ST_OK;
                case (flags.kind)
                    KIND_CREATE:
                    begin
                        if (flags.pool)
                        begin
                            st_next = ST_EXISTS;
                        end
                    end
                    KIND_DESTROY:
                    begin
                        st_next = ST_OK;
                    end
                    KIND_ALLOC:
                    begin
                        if (!flags.pool)
                        begin
                            st_next = ST_NO_POOL;
                        end
                        else if (flags.exceeded)
                        begin
                            st_next = ST_EXCEEDED;
                        end
                        else if (flags.req_zero)
                        begin
                            st_next = ST_NO_SPACE;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    default:
                    begin
                        if (flags.is_null)
                        begin
                            st_next = ST_OK;
                        end
                        else if (!flags.pool)
                        begin
                            st_next = ST_NO_POOL;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (flags.idx_end)
                begin
                    state_next = S_FIN;
                    st_next    = (flags.kind == KIND_ALLOC) ? ST_NO_SPACE : ST_NOT_FOUND;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (!flags.hit)
                begin
                    state_next = S_SCAN_RD;
                end
                else if (flags.kind == KIND_ALLOC)
                begin
                    state_next = S_ALLOC_DEC;
                end
                else
                begin
                    state_next = S_NX_RD;
                end
            end
            S_ALLOC_DEC:
            begin
                if (flags.exact)
                begin
                    state_next = S_FIN;
                    st_next    = ST_OK;
                end
                else if (flags.full)
                begin
                    state_next = S_FIN;
                    st_next    = ST_NO_SPACE;
                end
                else
                begin
                    state_next = S_SHUP_RD;
                end
            end
            S_SHUP_RD:
            begin
                state_next = flags.ptr_gt_idx ? S_SHUP_WR : S_SPLIT_LO;
            end
            S_SHUP_WR:
            begin
                state_next = S_SHUP_RD;
            end
            S_SPLIT_LO:
            begin
                state_next = S_SPLIT_HI;
            end
            S_SPLIT_HI:
            begin
                state_next = S_FIN;
                st_next    = ST_OK;
            end
            S_NX_RD:
            begin
                state_next = flags.has_next ? S_NX_CHK : S_PV_RD;
            end
            S_NX_CHK:
            begin
                state_next = S_PV_RD;
            end
            S_PV_RD:
            begin
                state_next = flags.has_prev ? S_PV_CHK : S_MERGE_WR;
            end
            S_PV_CHK:
            begin
                state_next = S_MERGE_WR;
            end
            S_MERGE_WR:
            begin
                state_next = S_SHDN_RD;
            end
            S_SHDN_RD:
            begin
                if (flags.shdn_end)
                begin
                    state_next = S_FIN;
                    st_next    = ST_OK;
                end
                else
                begin
                    state_next = S_SHDN_WR;
                end
            end
            S_SHDN_WR:
            begin
                state_next = S_SHDN_RD;
            end
            S_FIN:
            begin
                if (flags.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.status   = st_reg;
        cmd.in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (flags.in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            S_DECODE:
            begin
                case (flags.kind)
                    KIND_CREATE:
                    begin
                        if (!flags.pool)
                        begin
                            cmd.op = OP_CREATE;
                        end
                    end
                    KIND_DESTROY:
                    begin
                        cmd.op = OP_DESTROY;
                    end
                    default:
                    begin
                        cmd.op = OP_SCAN_INIT;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (!flags.idx_end)
                begin
                    cmd.op = OP_SCAN_RD;
                end
            end
            S_SCAN_CHK:
            begin
                if (!flags.hit)
                begin
                    cmd.op = OP_SCAN_NEXT;
                end
                else if (flags.kind == KIND_ALLOC)
                begin
                    cmd.op = OP_HIT;
                end
                else
                begin
                    cmd.op = OP_FREE_HIT;
                end
            end
            S_ALLOC_DEC:
            begin
                if (flags.exact)
                begin
                    cmd.op = OP_EXACT;
                end
                else if (!flags.full)
                begin
                    cmd.op = OP_SHUP_INIT;
                end
            end
            S_SHUP_RD:
            begin
                if (flags.ptr_gt_idx)
                begin
                    cmd.op = OP_SHUP_RD;
                end
            end
            S_SHUP_WR:  cmd.op = OP_SHUP_WR;
            S_SPLIT_LO: cmd.op = OP_SPLIT_LO;
            S_SPLIT_HI: cmd.op = OP_SPLIT_HI;
            S_NX_RD:
            begin
                if (flags.has_next)
                begin
                    cmd.op = OP_NX_RD;
                end
            end
            S_NX_CHK:
            begin
                if (flags.rd_free)
                begin
                    cmd.op = OP_NX_MERGE;
                end
            end
            S_PV_RD:
            begin
                if (flags.has_prev)
                begin
                    cmd.op = OP_PV_RD;
                end
            end
            S_PV_CHK:
            begin
                if (flags.rd_free)
                begin
                    cmd.op = OP_PV_MERGE;
                end
            end
            S_MERGE_WR: cmd.op = OP_MERGE_WR;
            S_SHDN_RD:  cmd.op = flags.shdn_end ? OP_SHDN_DONE : OP_SHDN_RD;
            S_SHDN_WR:  cmd.op = OP_SHDN_WR;
            S_FIN:
            begin
                if (flags.out_free)
                begin
                    cmd.op = OP_FINISH;
                end
            end
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

// File: rtl/ffsa_dp.sv
module ffsa_dp import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = 32,
    parameter int OFFSET_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [SIZE_BITS-1:0] pool_size,
    input  ctl_cmd_t             cmd,
    output dp_flags_t            flags,
    ffsa_req_if.sink             req,
    ffsa_rsp_if.source           rsp
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int IW = $clog2(MAX_SEGMENTS + 1);
    localparam int OW = OFFSET_BITS;
    localparam int EW = OW + SIZE_BITS + 1;

    logic [KIND_BITS-1:0]   kind_reg;
    logic [SIZE_BITS-1:0]   req_reg;
    logic [SIZE_BITS-1:0]   addr_reg;
    logic                   null_reg;
    logic                   pool_reg;
    logic [SIZE_BITS-1:0]   used_reg;
    logic [IW-1:0]          count_reg;
    logic [IW-1:0]          idx_reg;
    logic [IW-1:0]          ptr_reg;
    logic [OW-1:0]          hit_start_reg;
    logic [SIZE_BITS-1:0]   hit_size_reg;
    logic [SIZE_BITS-1:0]   acc_reg;
    logic [OW-1:0]          base_reg;
    logic                   nfree_reg;
    logic                   pfree_reg;
    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic [SIZE_BITS-1:0]   out_offset_reg;

    logic                   we;
    logic [AW-1:0]          waddr;
    logic [EW-1:0]          wdata;
    logic [AW-1:0]          raddr;
    logic [EW-1:0]          rdata;
    logic [OW-1:0]          rd_start;
    logic [SIZE_BITS-1:0]   rd_size;
    logic                   rd_free;

    logic [OW+15:0]         req_wide;
    logic [OW+15:0]         addr_wide;
    logic [OW+15:0]         hit_wide;
    logic [1:0]             drop;
    logic [IW-1:0]          drop_w;
    logic [IW-1:0]          idx_p1;

    assign rd_start  = rdata[EW-1 -: OW];
    assign rd_size   = rdata[SIZE_BITS:1];
    assign rd_free   = rdata[0];
    assign req_wide  = {{OW{1'b0}}, req_reg};
    assign addr_wide = {{OW{1'b0}}, addr_reg};
    assign hit_wide  = {16'b0, hit_start_reg};
    assign drop      = {1'b0, nfree_reg} + {1'b0, pfree_reg};
    assign drop_w    = IW'(drop);
    assign idx_p1    = idx_reg + IW'(1);

    ffsa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        raddr = idx_reg[AW-1:0];
        case (cmd.op)
            OP_SHUP_RD, OP_SHDN_RD: raddr = ptr_reg[AW-1:0];
            OP_NX_RD:               raddr = idx_p1[AW-1:0];
            OP_PV_RD:               raddr = idx_reg[AW-1:0] - AW'(1);
            default:                raddr = idx_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = {hit_start_reg, hit_size_reg, 1'b0};
        case (cmd.op)
            OP_CREATE:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = {{OW{1'b0}}, pool_size, 1'b1};
            end
            OP_EXACT:
            begin
                we = 1'b1;
            end
            OP_SHUP_WR:
            begin
                we    = 1'b1;
                waddr = ptr_reg[AW-1:0] + AW'(1);
                wdata = rdata;
            end
            OP_SPLIT_LO:
            begin
                we    = 1'b1;
                wdata = {hit_start_reg, req_reg, 1'b0};
            end
            OP_SPLIT_HI:
            begin
                we    = 1'b1;
                waddr = idx_p1[AW-1:0];
                wdata = {hit_start_reg + req_wide[OW-1:0], hit_size_reg - req_reg, 1'b1};
            end
            OP_MERGE_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg[AW-1:0] - AW'(pfree_reg);
                wdata = {base_reg, acc_reg, 1'b1};
            end
            OP_SHDN_WR:
            begin
                we    = 1'b1;
                waddr = ptr_reg[AW-1:0] - AW'(drop);
                wdata = rdata;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg      <= 1'b0;
            used_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_CREATE:
                begin
                    pool_reg  <= 1'b1;
                    used_reg  <= '0;
                    count_reg <= (pool_size != '0) ? IW'(1) : '0;
                end
                OP_DESTROY:
                begin
                    pool_reg  <= 1'b0;
                    used_reg  <= '0;
                    count_reg <= '0;
                end
                OP_EXACT:
                begin
                    used_reg <= used_reg + req_reg;
                end
                OP_SPLIT_LO:
                begin
                    used_reg  <= used_reg + req_reg;
                    count_reg <= count_reg + IW'(1);
                end
                OP_FREE_HIT:
                begin
                    used_reg <= used_reg - rd_size;
                end
                OP_SHDN_DONE:
                begin
                    count_reg <= count_reg - drop_w;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg <= req.kind;
                req_reg  <= req.request_size;
                addr_reg <= req.block_addr;
                null_reg <= req.block_null;
            end
            OP_SCAN_INIT:
            begin
                idx_reg <= '0;
            end
            OP_SCAN_NEXT:
            begin
                idx_reg <= idx_p1;
            end
            OP_HIT:
            begin
                hit_start_reg <= rd_start;
                hit_size_reg  <= rd_size;
            end
            OP_SHUP_INIT:
            begin
                ptr_reg <= count_reg - IW'(1);
            end
            OP_SHUP_WR:
            begin
                ptr_reg <= ptr_reg - IW'(1);
            end
            OP_FREE_HIT:
            begin
                acc_reg   <= rd_size;
                base_reg  <= rd_start;
                nfree_reg <= 1'b0;
                pfree_reg <= 1'b0;
            end
            OP_NX_MERGE:
            begin
                acc_reg   <= acc_reg + rd_size;
                nfree_reg <= 1'b1;
            end
            OP_PV_MERGE:
            begin
                acc_reg   <= acc_reg + rd_size;
                base_reg  <= rd_start;
                pfree_reg <= 1'b1;
            end
            OP_MERGE_WR:
            begin
                ptr_reg <= idx_p1 + IW'(nfree_reg);
            end
            OP_SHDN_WR:
            begin
                ptr_reg <= ptr_reg + IW'(1);
            end
            OP_FINISH:
            begin
                out_status_reg <= cmd.status;
                out_offset_reg <= (cmd.status == ST_OK && kind_reg == KIND_ALLOC)
                                  ? hit_wide[15:0] : '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        flags.in_valid   = req.valid;
        flags.out_free   = !out_valid_reg || rsp.ready;
        flags.kind       = kind_reg;
        flags.pool       = pool_reg;
        flags.exceeded   = ({1'b0, used_reg} + {1'b0, req_reg}) > {1'b0, pool_size};
        flags.req_zero   = (req_reg == '0);
        flags.is_null    = null_reg;
        flags.idx_end    = (idx_reg >= count_reg);
        flags.hit        = (kind_reg == KIND_ALLOC)
                           ? (rd_free && rd_size >= req_reg)
                           : (!rd_free && rd_start == addr_wide[OW-1:0]);
        flags.exact      = (hit_size_reg == req_reg);
        flags.full       = (count_reg >= IW'(MAX_SEGMENTS));
        flags.ptr_gt_idx = (ptr_reg > idx_reg);
        flags.has_next   = (idx_p1 < count_reg);
        flags.has_prev   = (idx_reg != '0);
        flags.rd_free    = rd_free;
        flags.shdn_end   = (drop == 2'd0) || (ptr_reg >= count_reg);
    end

    assign req.ready  = cmd.in_ready;
    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.offset = out_offset_reg;

endmodule

// File: rtl/first_fit_segment_allocator.sv
// Channel  Dir  Fields                                          Handshake
// req      in   kind, request_size, block_addr, block_null      valid/ready
// rsp      out  status, offset                                  valid/ready
// apb      in   paddr, pwdata (pool_size), prdata               psel/penable/pready
//
// One request at a time. Create, destroy and early rejects go from decode
// straight to finish. Alloc and free scan the segment table one entry at a
// time through the single read port of the table RAM, then shift the entries
// past the hit one by one, opening or closing the gap of a split or merge.
// Reset clears pool, count and used total; the table needs no clearing.
// A finished response waits in the output register; the next request is
// taken meanwhile and stalls only at its own finish.
`include "assert_macros.svh"

module first_fit_segment_allocator import ffsa_pkg::*; #(
    parameter int MAX_SEGMENTS = 32,
    parameter int OFFSET_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    ffsa_req_if.sink    req,
    ffsa_rsp_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SIZE_BITS-1:0] pool_size_reg;
    ctl_cmd_t             cmd;
    dp_flags_t            flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            pool_size_reg <= pwdata[SIZE_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'b0, pool_size_reg} : '0;

    ffsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cmd   (cmd)
    );

    ffsa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .pool_size (pool_size_reg),
        .cmd       (cmd),
        .flags     (flags),
        .req       (req),
        .rsp       (rsp)
    );

    `FFSA_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, !req.ready, "ready after request")
    `FFSA_ASSERT_SAME(a_ofs_zero, rsp.valid && rsp.status != ST_OK, rsp.offset == '0, "offset on error")
    `FFSA_ASSERT_SAME(a_status_range, rsp.valid, rsp.status <= ST_NOT_FOUND, "bad status code")

endmodule

// File: tb/tb_first_fit_segment_allocator.sv
module tb_first_fit_segment_allocator;
    import ffsa_pkg::*;

    localparam int NSEG = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [SIZE_BITS-1:0] request_size;
        logic [SIZE_BITS-1:0] block_addr;
        logic                 block_null;
    } request_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [SIZE_BITS-1:0]   offset;
    } response_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ffsa_req_if req_ch();
    ffsa_rsp_if rsp_ch();

    first_fit_segment_allocator DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch.sink),
        .rsp(rsp_ch.source),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // allocator shadow state
    logic [15:0] sh_start [NSEG];
    logic [15:0] sh_size [NSEG];
    logic        sh_free [NSEG];
    int          sh_count;
    logic [15:0] sh_used;
    logic        sh_pool;
    logic [15:0] sh_pool_size;

    request_t    pending_requests[$];
    response_t   expected_responses[$];
    logic [15:0] live_blocks[$];

    int          error_count;
    int          accepted_requests;
    int          checked_responses;
    int          idle_cycles;
    int          hold_off;
    int          req_wait;
    int          req_seen;
    int          rsp_wait;
    int          n_ok;
    int          n_fail_status;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void remove_entry(input int idx);
        for (int j = idx; j < sh_count - 1; j++)
        begin
            sh_start[j] = sh_start[j+1];
            sh_size[j]  = sh_size[j+1];
            sh_free[j]  = sh_free[j+1];
        end
        sh_count--;
    endfunction

    function automatic response_t predict_allocation(input request_t r);
        response_t res;
        int        i;
        logic [15:0] st;
        res.status = ST_OK;
        res.offset = '0;
        case (r.kind)
            KIND_ALLOC:
            begin
                if (!sh_pool)
                    res.status = ST_NO_POOL;
                else if (17'(sh_used) + 17'(r.request_size) > 17'(sh_pool_size))
                    res.status = ST_EXCEEDED;
                else if (r.request_size == 0)
                    res.status = ST_NO_SPACE;
                else
                begin
                    for (i = 0; i < sh_count; i++)
                        if (sh_free[i] && sh_size[i] >= r.request_size)
                            break;
                    if (i >= sh_count)
                        res.status = ST_NO_SPACE;
                    else if (sh_size[i] == r.request_size)
                    begin
                        sh_free[i] = 1'b0;
                        res.offset = sh_start[i];
                    end
                    else if (sh_count >= NSEG)
                        res.status = ST_NO_SPACE;
                    else
                    begin
                        st = sh_start[i];
                        for (int j = sh_count; j > i; j--)
                        begin
                            sh_start[j] = sh_start[j-1];
                            sh_size[j]  = sh_size[j-1];
                            sh_free[j]  = sh_free[j-1];
                        end
                        sh_count++;
                        sh_size[i]    = r.request_size;
                        sh_free[i]    = 1'b0;
                        sh_start[i+1] = st + r.request_size;
                        sh_size[i+1]  = sh_size[i+1] - r.request_size;
                        sh_free[i+1]  = 1'b1;
                        res.offset    = st;
                    end
                    if (res.status == ST_OK)
                        sh_used = sh_used + r.request_size;
                end
            end
            KIND_FREE:
            begin
                if (!r.block_null)
                begin
                    if (!sh_pool)
                        res.status = ST_NO_POOL;
                    else
                    begin
                        for (i = 0; i < sh_count; i++)
                            if (!sh_free[i] && sh_start[i] == r.block_addr)
                                break;
                        if (i >= sh_count)
                            res.status = ST_NOT_FOUND;
                        else
                        begin
                            sh_free[i] = 1'b1;
                            sh_used = sh_used - sh_size[i];
                            if (i + 1 < sh_count && sh_free[i+1])
                            begin
                                sh_size[i] = sh_size[i] + sh_size[i+1];
                                remove_entry(i + 1);
                            end
                            if (i > 0 && sh_free[i-1])
                            begin
                                sh_size[i-1] = sh_size[i-1] + sh_size[i];
                                remove_entry(i);
                            end
                        end
                    end
                end
            end
            KIND_CREATE:
            begin
                if (sh_pool)
                    res.status = ST_EXISTS;
                else
                begin
                    sh_pool  = 1'b1;
                    sh_used  = '0;
                    sh_count = 0;
                    if (sh_pool_size != 0)
                    begin
                        sh_start[0] = '0;
                        sh_size[0]  = sh_pool_size;
                        sh_free[0]  = 1'b1;
                        sh_count    = 1;
                    end
                end
            end
            default:
            begin
                sh_pool  = 1'b0;
                sh_count = 0;
                sh_used  = '0;
            end
        endcase
        return res;
    endfunction

    function automatic request_t make_req(input logic [1:0] k, input logic [15:0] sz,
                                          input logic [15:0] ad, input logic nl);
        request_t r;
        r.kind = k;
        r.request_size = sz;
        r.block_addr = ad;
        r.block_null = nl;
        return r;
    endfunction

    task automatic apb_write(input logic [1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sh_pool_size = data[15:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_responses.size() != 0)
            @(posedge clk);
        repeat (4 * NSEG + 16) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        int          roll;
        logic [15:0] sz;
        logic [15:0] ad;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                case ($urandom_range(0, 3))
                    0: sz = 16'($urandom_range(1, 16));
                    1: sz = 16'($urandom_range(1, 300));
                    2: sz = 16'($urandom);
                    default: sz = 16'($urandom_range(0, 2));
                endcase
                pending_requests.push_back(make_req(KIND_ALLOC, sz, 16'($urandom),
                                                    1'($urandom)));
            end
            else if (roll < 88)
            begin
                if (live_blocks.size() != 0 && $urandom_range(0, 9) < 8)
                    ad = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                else
                    ad = 16'($urandom);
                pending_requests.push_back(make_req(KIND_FREE, 16'($urandom), ad,
                                                    $urandom_range(0, 15) == 0));
            end
            else if (roll < 95)
                pending_requests.push_back(make_req(KIND_CREATE, 16'($urandom),
                                                    16'($urandom), 1'($urandom)));
            else
                pending_requests.push_back(make_req(KIND_DESTROY, 16'($urandom),
                                                    16'($urandom), 1'($urandom)));
        end
    endtask

    // request driver
    always @(negedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_wait     <= 0;
            req_seen     <= 0;
        end
        else if (req_ch.valid && accepted_requests != req_seen)
        begin
            req_seen <= accepted_requests;
            gap = $urandom_range(0, 12);
            if (gap == 0 && pending_requests.size() != 0)
            begin
                req_ch.kind         <= pending_requests[0].kind;
                req_ch.request_size <= pending_requests[0].request_size;
                req_ch.block_addr   <= pending_requests[0].block_addr;
                req_ch.block_null   <= pending_requests[0].block_null;
            end
            else
            begin
                req_ch.valid <= 1'b0;
                req_wait     <= gap;
            end
        end
        else if (!req_ch.valid)
        begin
            if (req_wait > 0)
                req_wait <= req_wait - 1;
            else if (pending_requests.size() != 0)
            begin
                req_ch.valid        <= 1'b1;
                req_ch.kind         <= pending_requests[0].kind;
                req_ch.request_size <= pending_requests[0].request_size;
                req_ch.block_addr   <= pending_requests[0].block_addr;
                req_ch.block_null   <= pending_requests[0].block_null;
            end
        end
    end

    // accept and predict
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            expected_responses.push_back(predict_allocation(pending_requests.pop_front()));
            accepted_requests++;
        end
    end

    // response ready
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_wait     <= 0;
        end
        else if (hold_off > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_off     <= hold_off - 1;
        end
        else if (rsp_ch.ready && rsp_ch.valid)
        begin
            if ($urandom_range(0, 2) == 0)
                rsp_wait <= 0;
            else
            begin
                rsp_ch.ready <= 1'b0;
                rsp_wait     <= $urandom_range(0, 12);
            end
        end
        else if (!rsp_ch.ready)
        begin
            if (rsp_wait > 0)
                rsp_wait <= rsp_wait - 1;
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        response_t exp_r;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_responses.size() == 0)
            begin
                $error("unexpected response status=%0d offset=%0d",
                       rsp_ch.status, rsp_ch.offset);
                error_count++;
            end
            else
            begin
                exp_r = expected_responses.pop_front();
                checked_responses++;
                if (exp_r.status == ST_OK)
                    n_ok++;
                else
                    n_fail_status++;
                if (rsp_ch.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.offset !== exp_r.offset)
                begin
                    $error("offset expected %0d actual %0d", exp_r.offset, rsp_ch.offset);
                    error_count++;
                end
                if (exp_r.status == ST_OK && rsp_ch.offset !== 16'd0)
                    live_blocks.push_back(rsp_ch.offset);
                if (live_blocks.size() > 40)
                    void'(live_blocks.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_ALLOC;
        req_ch.request_size = '0;
        req_ch.block_addr = '0;
        req_ch.block_null = 1'b0;
        rsp_ch.ready = 1'b0;
        error_count = 0;
        accepted_requests = 0;
        checked_responses = 0;
        idle_cycles = 0;
        hold_off = 0;
        n_ok = 0;
        n_fail_status = 0;
        sh_count = 0;
        sh_used = '0;
        sh_pool = 1'b0;
        sh_pool_size = '0;
        for (int i = 0; i < NSEG; i++)
        begin
            sh_start[i] = '0;
            sh_size[i] = '0;
            sh_free[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: no pool, empty pool, full range, exact fit, table full
        pending_requests.push_back(make_req(KIND_ALLOC, 16'd4, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_FREE, 16'd0, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_DESTROY, 16'd0, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_CREATE, 16'd0, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_ALLOC, 16'd0, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_ALLOC, 16'd1, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_DESTROY, 16'd0, 16'd0, 1'b0));
        wait_drained();
        apb_write(2'd0, 32'hFFFF);
        pending_requests.push_back(make_req(KIND_CREATE, 16'd0, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_CREATE, 16'd0, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_ALLOC, 16'hFFFF, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_ALLOC, 16'd1, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_FREE, 16'd0, 16'hFFFF, 1'b1));
        pending_requests.push_back(make_req(KIND_FREE, 16'd0, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_FREE, 16'd0, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_FREE, 16'd0, 16'd7, 1'b0));
        for (int i = 0; i < 33; i++)
            pending_requests.push_back(make_req(KIND_ALLOC, 16'd2, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_FREE, 16'd0, 16'd2, 1'b0));
        pending_requests.push_back(make_req(KIND_ALLOC, 16'd2, 16'd0, 1'b0));
        pending_requests.push_back(make_req(KIND_DESTROY, 16'd0, 16'd0, 1'b0));
        wait_drained();

        // long receiver stall while requests keep arriving
        apb_write(2'd0, 32'd1000);
        @(negedge clk);
        hold_off = 300;
        pending_requests.push_back(make_req(KIND_CREATE, 16'd0, 16'd0, 1'b0));
        random_phase(30);
        wait_drained();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: apb_write(2'd0, 32'd64);
                1: apb_write(2'd0, 32'd500);
                2: apb_write(2'd0, 32'd0);
                3: apb_write(2'd0, 32'd4000);
                4: apb_write(2'd0, 32'($urandom));
                default: apb_write(2'd0, 32'hFFFF);
            endcase
            pending_requests.push_back(make_req(KIND_DESTROY, 16'd0, 16'd0, 1'b0));
            pending_requests.push_back(make_req(KIND_CREATE, 16'd0, 16'd0, 1'b0));
            random_phase(115);
            wait_drained();
        end

        $display("Checked %0d responses from %0d requests (%0d ok, %0d rejected).",
                 checked_responses, accepted_requests, n_ok, n_fail_status);
        $display("Covered pool sizes 0..65535, splits, merges, full table and stalls.");
        if (error_count == 0 && expected_responses.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: first_fit_segment_allocator.f
+incdir+rtl
rtl/ffsa_pkg.sv
rtl/ffsa_if.sv
rtl/ffsa_ram.sv
rtl/ffsa_ctrl.sv
rtl/ffsa_dp.sv
rtl/first_fit_segment_allocator.sv
tb/tb_first_fit_segment_allocator.sv
